// ----- rtl/ffa_pkg.sv -----
// Shared constants, status codes and sequencer states of the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffa_pkg;

  // Block bookkeeping is kept in 16-byte granules.
  localparam int GRAIN_LOG  = 4;
  localparam int HEAD_BYTES = 40;
  localparam int OVERHEAD   = 48;

  // Defaults for the top-level parameters.
  localparam int DEF_PAGE_BYTES  = 4096;
  localparam int DEF_MAX_PAGES   = 64;
  localparam int DEF_ALIGN_BYTES = 16;

  // Reset value of the page limit register.
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  // Request types.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_OOM       = 3'd2,
    ST_NOT_BLOCK = 3'd3,
    ST_DOUBLE    = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_WRD,
    S_WEV,
    S_GROW,
    S_TAKE,
    S_TLINK,
    S_TMARK,
    S_FT,
    S_FTEV,
    S_FNRD,
    S_FNEV,
    S_FNLK,
    S_FP,
    S_FPEV,
    S_FP2,
    S_FP3,
    S_FPLK,
    S_DONE
  } ffa_state_t;

endpackage
`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator: configuration register and unit wiring.
//
// Usage: a request word (in_req_type, in_request_bytes, in_user_offset) is taken
// when start is high and busy is low. Exactly one result word follows, shown for
// one cycle with out_valid high; the receiver cannot stall it and must take it.
// Requests are handled one at a time; busy stays high until the result cycle ends,
// so the next request can be taken at the edge that ends the cycle after it.
// Sequence: an allocate walks the blocks in address order, then sizes, splits
// and marks the chosen block; a free walks the blocks up to its target, then
// checks it and merges it with free neighbours. Each walk step is one registered
// read of the block table memory, which has a read port apart from its write
// ports.
// Configuration: page_limit sits at byte address 0 of the register port, read
// and written through it, a write taking effect when psel and penable are high;
// pready is always high. Write it only while busy is low.
// Reset: synchronous, active low. The heap is one free page at offset 0, nothing
// is allocated and page_limit is 64. No memory clearing pass is needed, so the
// block accepts requests as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator
  import ffa_pkg::*;
#(
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int MAX_PAGES   = DEF_MAX_PAGES,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [18:0] in_request_bytes,
  input  wire logic [17:0] in_user_offset,
  output logic             out_valid,
  output logic [2:0]       out_status,
  output logic [17:0]      out_granted_offset,
  output logic [18:0]      out_used_total,
  output logic [14:0]      out_blocks_now,
  output logic [6:0]       out_heap_pages_now,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PAGE_GRAINS = PAGE_BYTES >> GRAIN_LOG;
  localparam int IW          = $clog2(MAX_PAGES * PAGE_GRAINS);

  logic [6:0] page_limit_r;

  // Page limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      page_limit_r <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, page_limit_r} : 32'd0;

  logic [IW-1:0] rd_addr;
  logic [IW+1:0] bt_rdata;
  logic [IW-1:0] pl_rdata;
  logic          bt_we;
  logic [IW-1:0] bt_waddr;
  logic [IW+1:0] bt_wdata;
  logic          pl_we;
  logic [IW-1:0] pl_waddr;
  logic [IW-1:0] pl_wdata;

  ffa_ctrl #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_PAGES  (MAX_PAGES),
    .ALIGN_BYTES(ALIGN_BYTES),
    .IW         (IW)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_request_bytes  (in_request_bytes),
    .in_user_offset    (in_user_offset),
    .page_limit        (page_limit_r),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_offset(out_granted_offset),
    .out_used_total    (out_used_total),
    .out_blocks_now    (out_blocks_now),
    .out_heap_pages_now(out_heap_pages_now),
    .rd_addr           (rd_addr),
    .bt_rdata          (bt_rdata),
    .pl_rdata          (pl_rdata),
    .bt_we             (bt_we),
    .bt_waddr          (bt_waddr),
    .bt_wdata          (bt_wdata),
    .pl_we             (pl_we),
    .pl_waddr          (pl_waddr),
    .pl_wdata          (pl_wdata)
  );

  ffa_mem #(
    .IW         (IW),
    .PAGE_GRAINS(PAGE_GRAINS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .bt_rdata(bt_rdata),
    .pl_rdata(pl_rdata),
    .bt_we   (bt_we),
    .bt_waddr(bt_waddr),
    .bt_wdata(bt_wdata),
    .pl_we   (pl_we),
    .pl_waddr(pl_waddr),
    .pl_wdata(pl_wdata)
  );

endmodule
`default_nettype wire

// ----- rtl/ffa_mem.sv -----
// Block table and previous-link memories with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffa_mem
  import ffa_pkg::*;
#(
  parameter int IW          = 14,
  parameter int PAGE_GRAINS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [IW-1:0] rd_addr,
  output logic      [IW+1:0] bt_rdata,
  output logic      [IW-1:0] pl_rdata,
  input  wire logic          bt_we,
  input  wire logic [IW-1:0] bt_waddr,
  input  wire logic [IW+1:0] bt_wdata,
  input  wire logic          pl_we,
  input  wire logic [IW-1:0] pl_waddr,
  input  wire logic [IW-1:0] pl_wdata
);

  localparam int DEPTH = 1 << IW;
  localparam logic [IW+1:0] ENTRY0_RESET = {1'b0, (IW+1)'(PAGE_GRAINS)};

  logic [IW+1:0] bt_mem [DEPTH];
  logic [IW-1:0] pl_mem [DEPTH];
  logic [IW+1:0] bt_q_r;
  logic [IW-1:0] pl_q_r;
  logic          zero_valid_r;
  logic          rd_zero_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (bt_we) begin
      bt_mem[bt_waddr] <= bt_wdata;
    end
    if (pl_we) begin
      pl_mem[pl_waddr] <= pl_wdata;
    end
    bt_q_r <= bt_mem[rd_addr];
    pl_q_r <= pl_mem[rd_addr];
  end

  // Entry zero reads as one free page until it is first written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_valid_r <= 1'b0;
      rd_zero_r    <= 1'b0;
    end else begin
      rd_zero_r <= (rd_addr == '0) && !zero_valid_r;
      if (bt_we && (bt_waddr == '0)) begin
        zero_valid_r <= 1'b1;
      end
    end
  end

  assign bt_rdata = rd_zero_r ? ENTRY0_RESET : bt_q_r;
  assign pl_rdata = pl_q_r;

endmodule
`default_nettype wire

// ----- rtl/ffa_ctrl.sv -----
// Request sequencer and datapath: first-fit walk, split, heap growth and coalescing.
`timescale 1ns / 1ps
`default_nettype none
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int PAGE_BYTES  = DEF_PAGE_BYTES,
  parameter int MAX_PAGES   = DEF_MAX_PAGES,
  parameter int ALIGN_BYTES = DEF_ALIGN_BYTES,
  parameter int IW          = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_req_type,
  input  wire logic [18:0]   in_request_bytes,
  input  wire logic [17:0]   in_user_offset,
  input  wire logic [6:0]    page_limit,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [17:0]        out_granted_offset,
  output logic [18:0]        out_used_total,
  output logic [14:0]        out_blocks_now,
  output logic [6:0]         out_heap_pages_now,
  output logic [IW-1:0]      rd_addr,
  input  wire logic [IW+1:0] bt_rdata,
  input  wire logic [IW-1:0] pl_rdata,
  output logic               bt_we,
  output logic [IW-1:0]      bt_waddr,
  output logic [IW+1:0]      bt_wdata,
  output logic               pl_we,
  output logic [IW-1:0]      pl_waddr,
  output logic [IW-1:0]      pl_wdata
);

  localparam int SW        = IW + 1;
  localparam int HW        = $clog2(MAX_PAGES + 1);
  localparam int LW        = (HW > 7) ? HW : 7;
  localparam int PGL       = $clog2(PAGE_BYTES) - GRAIN_LOG;
  localparam int AL        = $clog2(ALIGN_BYTES);
  localparam int PBL       = $clog2(PAGE_BYTES);
  localparam int CW        = (SW + 1 > 21) ? SW + 1 : 21;
  localparam int UW        = SW + GRAIN_LOG;
  localparam int MIN_SPLIT = OVERHEAD + ALIGN_BYTES;

  ffa_state_t state_r, state_nxt;

  logic          type_r;
  logic [18:0]   req_bytes_r;
  logic [17:0]   off_r;
  logic [SW-1:0] i_r, last_r, t_r, j_r, n_r, sz_r;
  logic [IW-1:0] p_r;
  logic [CW-1:0] need_r, pages_r;
  status_t       status_r;
  logic [UW-1:0] granted_r, used_r;
  logic [SW-1:0] blocks_r;
  logic [HW-1:0] heap_r;

  // Decoded memory word and heap end.
  logic          bt_used;
  logic [SW-1:0] bt_size;
  logic [SW-1:0] end_w;
  assign bt_used = bt_rdata[SW];
  assign bt_size = bt_rdata[SW-1:0];
  assign end_w   = SW'(heap_r) << PGL;

  // Request size arithmetic.
  logic [CW-1:0] aligned_w, total_w, need_w, pages_w;
  assign aligned_w = ((CW'(req_bytes_r) + CW'(ALIGN_BYTES - 1)) >> AL) << AL;
  assign total_w   = aligned_w + CW'(OVERHEAD);
  assign need_w    = (total_w + CW'(15)) >> GRAIN_LOG;
  assign pages_w   = (total_w + CW'(PAGE_BYTES - 1)) >> PBL;

  // Free offset checks.
  logic [17:0] t_full_w;
  logic        off_zero_w, off_bad_w, off_past_w;
  assign t_full_w   = (off_r - 18'(HEAD_BYTES)) >> GRAIN_LOG;
  assign off_zero_w = (off_r == '0);
  assign off_bad_w  = (off_r < 18'(HEAD_BYTES)) || (off_r[3:0] != 4'd8);
  assign off_past_w = CW'(t_full_w) >= CW'(end_w);

  // Walk decisions.
  logic walk_more_w, fit_w;
  assign walk_more_w = (type_r == REQ_ALLOC) ? (i_r < end_w) : (i_r < t_r);
  assign fit_w       = !bt_used && (CW'(bt_size) >= need_r);

  // Growth limit check.
  logic [LW-1:0] lim_w;
  logic          oom_w;
  assign lim_w = (LW'(page_limit) > LW'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(page_limit);
  assign oom_w = (LW'(heap_r) >= lim_w) || (pages_r > CW'(lim_w - LW'(heap_r)));

  // Split arithmetic.
  logic [SW-1:0] left_w, j_w, grow_sz_w;
  logic          split_w;
  assign left_w    = sz_r - SW'(need_r);
  assign j_w       = i_r + SW'(need_r);
  assign split_w   = (UW'(left_w) << GRAIN_LOG) >= UW'(MIN_SPLIT);
  assign grow_sz_w = SW'(pages_r) << PGL;

  // Coalesce sums.
  logic [SW-1:0] merge_w;
  assign merge_w = sz_r + bt_size;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_PREP;
      S_PREP: begin
        if (type_r == REQ_ALLOC) begin
          state_nxt = (req_bytes_r == '0) ? S_DONE : S_WRD;
        end else begin
          state_nxt = (off_zero_w || off_bad_w || off_past_w) ? S_DONE : S_WRD;
        end
      end
      S_WRD: begin
        if (walk_more_w) state_nxt = S_WEV;
        else if (type_r == REQ_ALLOC) state_nxt = S_GROW;
        else state_nxt = (i_r != t_r) ? S_DONE : S_FT;
      end
      S_WEV: begin
        if (type_r == REQ_ALLOC) begin
          if (fit_w) state_nxt = S_TAKE;
          else state_nxt = (bt_size == '0) ? S_GROW : S_WRD;
        end else begin
          state_nxt = (bt_size == '0) ? S_DONE : S_WRD;
        end
      end
      S_GROW:  state_nxt = oom_w ? S_DONE : S_TAKE;
      S_TAKE:  state_nxt = split_w ? S_TLINK : S_TMARK;
      S_TLINK: state_nxt = S_TMARK;
      S_TMARK: state_nxt = S_DONE;
      S_FT:    state_nxt = S_FTEV;
      S_FTEV:  state_nxt = bt_used ? S_FNRD : S_DONE;
      S_FNRD:  state_nxt = (n_r < end_w) ? S_FNEV : S_FP;
      S_FNEV:  state_nxt = bt_used ? S_FP : S_FNLK;
      S_FNLK:  state_nxt = S_FP;
      S_FP:    state_nxt = (t_r == '0) ? S_DONE : S_FPEV;
      S_FPEV:  state_nxt = S_FP2;
      S_FP2:   state_nxt = (SW'(p_r) < end_w) ? S_FP3 : S_DONE;
      S_FP3:   state_nxt = bt_used ? S_DONE : S_FPLK;
      S_FPLK:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    rd_addr  = i_r[IW-1:0];
    bt_we    = 1'b0;
    bt_waddr = i_r[IW-1:0];
    bt_wdata = {1'b0, sz_r};
    pl_we    = 1'b0;
    pl_waddr = n_r[IW-1:0];
    pl_wdata = i_r[IW-1:0];
    case (state_r)
      S_FT, S_FP: rd_addr = t_r[IW-1:0];
      S_FNRD:     rd_addr = n_r[IW-1:0];
      S_FP2:      rd_addr = p_r;
      S_GROW: begin
        if (!oom_w) begin
          bt_we    = 1'b1;
          bt_waddr = end_w[IW-1:0];
          bt_wdata = {1'b0, grow_sz_w};
          pl_we    = 1'b1;
          pl_waddr = end_w[IW-1:0];
          pl_wdata = last_r[IW-1:0];
        end
      end
      S_TAKE: begin
        if (split_w) begin
          bt_we    = 1'b1;
          bt_waddr = j_w[IW-1:0];
          bt_wdata = {1'b0, left_w};
          pl_we    = 1'b1;
          pl_waddr = j_w[IW-1:0];
          pl_wdata = i_r[IW-1:0];
        end
      end
      S_TLINK: begin
        pl_we    = n_r < end_w;
        pl_wdata = j_r[IW-1:0];
      end
      S_TMARK: begin
        bt_we    = 1'b1;
        bt_wdata = {1'b1, sz_r};
      end
      S_FTEV: begin
        bt_we    = bt_used;
        bt_waddr = t_r[IW-1:0];
        bt_wdata = {1'b0, bt_size};
      end
      S_FNEV: begin
        bt_we    = !bt_used;
        bt_waddr = t_r[IW-1:0];
        bt_wdata = {1'b0, merge_w};
      end
      S_FNLK: begin
        pl_we    = n_r < end_w;
        pl_wdata = t_r[IW-1:0];
      end
      S_FP3: begin
        bt_we    = !bt_used;
        bt_waddr = p_r;
        bt_wdata = {1'b0, merge_w};
      end
      S_FPLK: begin
        pl_we    = n_r < end_w;
        pl_wdata = p_r;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      blocks_r <= SW'(1);
      heap_r   <= HW'(1);
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_GROW: begin
          if (!oom_w) begin
            heap_r   <= heap_r + pages_r[HW-1:0];
            blocks_r <= blocks_r + SW'(1);
          end
        end
        S_TAKE:  if (split_w) blocks_r <= blocks_r + SW'(1);
        S_TMARK: used_r <= used_r + ((UW'(sz_r) << GRAIN_LOG) - UW'(OVERHEAD));
        S_FTEV: begin
          if (bt_used) used_r <= used_r - ((UW'(bt_size) << GRAIN_LOG) - UW'(OVERHEAD));
        end
        S_FNEV:  if (!bt_used) blocks_r <= blocks_r - SW'(1);
        S_FP3:   if (!bt_used) blocks_r <= blocks_r - SW'(1);
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        type_r      <= in_req_type;
        req_bytes_r <= in_request_bytes;
        off_r       <= in_user_offset;
        granted_r   <= '0;
        status_r    <= ST_OK;
      end
      S_PREP: begin
        i_r    <= '0;
        last_r <= '0;
        need_r  <= need_w;
        pages_r <= pages_w;
        t_r     <= SW'(t_full_w);
        if (type_r == REQ_ALLOC) begin
          if (req_bytes_r == '0) status_r <= ST_ZERO;
        end else if (!off_zero_w && (off_bad_w || off_past_w)) begin
          status_r <= ST_NOT_BLOCK;
        end
      end
      S_WRD: begin
        if (!walk_more_w && (type_r == REQ_FREE) && (i_r != t_r)) status_r <= ST_NOT_BLOCK;
      end
      S_WEV: begin
        if (type_r == REQ_ALLOC) begin
          if (fit_w) begin
            sz_r <= bt_size;
          end else begin
            last_r <= i_r;
            i_r    <= i_r + bt_size;
          end
        end else if (bt_size == '0) begin
          status_r <= ST_NOT_BLOCK;
        end else begin
          i_r <= i_r + bt_size;
        end
      end
      S_GROW: begin
        if (oom_w) begin
          status_r <= ST_OOM;
        end else begin
          i_r  <= end_w;
          sz_r <= grow_sz_w;
        end
      end
      S_TAKE: begin
        if (split_w) begin
          j_r  <= j_w;
          n_r  <= i_r + sz_r;
          sz_r <= SW'(need_r);
        end
      end
      S_TMARK: granted_r <= (UW'(i_r) << GRAIN_LOG) + UW'(HEAD_BYTES);
      S_FTEV: begin
        if (!bt_used) status_r <= ST_DOUBLE;
        sz_r <= bt_size;
        n_r  <= t_r + bt_size;
      end
      S_FNEV: begin
        if (!bt_used) begin
          sz_r <= merge_w;
          n_r  <= t_r + merge_w;
        end
      end
      S_FPEV: p_r <= pl_rdata;
      S_FP3:  n_r <= SW'(p_r) + merge_w;
      default: ;
    endcase
  end

  // Result word and handshake.
  assign busy               = (state_r != S_IDLE);
  assign out_valid          = (state_r == S_DONE);
  assign out_status         = status_r;
  assign out_granted_offset = 18'(granted_r);
  assign out_used_total     = 19'(used_r);
  assign out_blocks_now     = 15'(blocks_r);
  assign out_heap_pages_now = 7'(heap_r);

endmodule
`default_nettype wire

// ----- test/first_fit_heap_allocator_tb.sv -----
// Self-checking testbench for the first-fit heap allocator with split and coalesce.
`timescale 1ns / 1ps
module first_fit_heap_allocator_tb
  import ffa_pkg::*;
();

  localparam int PAGE_B      = 4096;
  localparam int MAXP        = 64;
  localparam int ALIGN_B     = 16;
  localparam int PAGE_GR     = PAGE_B / 16;
  localparam int ARENA_GR    = MAXP * PAGE_GR;
  localparam int MIN_SPLIT_B = OVERHEAD + ALIGN_B;

  // One result word as the block reports it.
  typedef struct packed {
    logic [2:0]  status;
    logic [17:0] granted;
    logic [18:0] used;
    logic [14:0] blocks;
    logic [6:0]  pages;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_req_type;
  logic [18:0] in_request_bytes;
  logic [17:0] in_user_offset;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [17:0] out_granted_offset;
  logic [18:0] out_used_total;
  logic [14:0] out_blocks_now;
  logic [6:0]  out_heap_pages_now;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_request_bytes(in_request_bytes),
    .in_user_offset(in_user_offset), .out_valid(out_valid),
    .out_status(out_status), .out_granted_offset(out_granted_offset),
    .out_used_total(out_used_total), .out_blocks_now(out_blocks_now),
    .out_heap_pages_now(out_heap_pages_now), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the heap metadata.
  logic        blk_used [ARENA_GR];
  int unsigned blk_size [ARENA_GR];
  int unsigned blk_prev [ARENA_GR];
  int unsigned pages_sh;
  int unsigned used_sh;
  int unsigned count_sh;
  int unsigned limit_sh;

  heap_result_t pending_results[$];
  int unsigned  live_offsets[$];
  int           fail_count;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Runaway guard.
  initial begin
    #50ms;
    $display("first_fit_heap_allocator test failed");
    $finish;
  end

  function automatic void heap_reset();
    blk_size[0] = PAGE_GR;
    blk_used[0] = 1'b0;
    blk_prev[0] = 0;
    pages_sh = 1;
    used_sh = 0;
    count_sh = 1;
    limit_sh = 64;
  endfunction

  // Marks block i used and splits off the tail when it is large enough.
  function automatic int unsigned claim_block(int unsigned i, int unsigned need);
    int unsigned top_gr;
    int unsigned sz;
    int unsigned rest;
    top_gr = pages_sh * PAGE_GR;
    sz = blk_size[i];
    rest = sz - need;
    if (rest * 16 >= MIN_SPLIT_B) begin
      blk_size[i + need] = rest;
      blk_used[i + need] = 1'b0;
      blk_prev[i + need] = i;
      if (i + sz < top_gr) blk_prev[i + sz] = i + need;
      sz = need;
      count_sh++;
    end
    blk_size[i] = sz;
    blk_used[i] = 1'b1;
    used_sh += sz * 16 - OVERHEAD;
    return i * 16 + HEAD_BYTES;
  endfunction

  function automatic status_t predict_alloc(int unsigned req, output int unsigned grant);
    int unsigned top_gr;
    int unsigned total;
    int unsigned need;
    int unsigned i;
    int unsigned last;
    int unsigned grow;
    int unsigned lim;
    top_gr = pages_sh * PAGE_GR;
    grant = 0;
    i = 0;
    last = 0;
    if (req == 0) return ST_ZERO;
    total = ((req + ALIGN_B - 1) / ALIGN_B) * ALIGN_B + OVERHEAD;
    need = (total + 15) / 16;
    while (i < top_gr) begin
      if (!blk_used[i] && blk_size[i] >= need) begin
        grant = claim_block(i, need);
        return ST_OK;
      end
      last = i;
      if (blk_size[i] == 0) break;
      i += blk_size[i];
    end
    grow = (total + PAGE_B - 1) / PAGE_B;
    lim = (limit_sh > MAXP) ? MAXP : limit_sh;
    if (pages_sh >= lim || grow > lim - pages_sh) return ST_OOM;
    pages_sh += grow;
    blk_size[top_gr] = grow * PAGE_GR;
    blk_used[top_gr] = 1'b0;
    blk_prev[top_gr] = last;
    count_sh++;
    grant = claim_block(top_gr, need);
    return ST_OK;
  endfunction

  function automatic status_t predict_free(int unsigned off);
    int unsigned top_gr;
    int unsigned t;
    int unsigned i;
    int unsigned sz;
    int unsigned n;
    int unsigned p;
    top_gr = pages_sh * PAGE_GR;
    i = 0;
    if (off == 0) return ST_OK;
    if (off < HEAD_BYTES || ((off - HEAD_BYTES) % 16) != 0) return ST_NOT_BLOCK;
    t = (off - HEAD_BYTES) / 16;
    if (t >= top_gr) return ST_NOT_BLOCK;
    while (i < t) begin
      if (blk_size[i] == 0) return ST_NOT_BLOCK;
      i += blk_size[i];
    end
    if (i != t) return ST_NOT_BLOCK;
    if (!blk_used[t]) return ST_DOUBLE;
    sz = blk_size[t];
    blk_used[t] = 1'b0;
    used_sh -= sz * 16 - OVERHEAD;
    n = t + sz;
    if (n < top_gr && !blk_used[n]) begin
      sz += blk_size[n];
      blk_size[t] = sz;
      if (t + sz < top_gr) blk_prev[t + sz] = t;
      count_sh--;
    end
    if (t != 0) begin
      p = blk_prev[t];
      if (p < top_gr && !blk_used[p]) begin
        blk_size[p] += sz;
        if (p + blk_size[p] < top_gr) blk_prev[p + blk_size[p]] = p;
        count_sh--;
      end
    end
    return ST_OK;
  endfunction

  // Sends one request word and queues the predicted result.
  task automatic send_request(logic kind, logic [18:0] nbytes, logic [17:0] off);
    heap_result_t exp_r;
    int unsigned grant;
    status_t st;
    @(negedge clk);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    in_req_type <= kind;
    in_request_bytes <= nbytes;
    in_user_offset <= off;
    @(posedge clk);
    while (busy) @(posedge clk);
    grant = 0;
    if (kind == REQ_ALLOC) st = predict_alloc(nbytes, grant);
    else st = predict_free(off);
    if (st != ST_OK) grant = 0;
    if (kind == REQ_ALLOC && st == ST_OK) live_offsets.push_back(grant);
    exp_r.status = st;
    exp_r.granted = grant[17:0];
    exp_r.used = used_sh[18:0];
    exp_r.blocks = count_sh[14:0];
    exp_r.pages = pages_sh[6:0];
    pending_results.push_back(exp_r);
    @(negedge clk);
    start <= 1'b0;
    in_req_type <= 1'($urandom_range(0, 1));
    in_request_bytes <= 19'($urandom);
    in_user_offset <= 18'($urandom);
  endtask

  task automatic free_word(int unsigned off);
    send_request(REQ_FREE, 19'd0, off[17:0]);
  endtask

  task automatic alloc_word(int unsigned nbytes);
    send_request(REQ_ALLOC, nbytes[18:0], 18'd0);
  endtask

  // Waits for every result, then long enough for the block to settle.
  task automatic drain_results();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_page_limit(int unsigned value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_sh = value & 32'h7f;
  endtask

  // Checks each result word against the oldest prediction.
  always @(posedge clk) begin
    heap_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word, status %0d", out_status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_status);
          fail_count++;
        end
        if (out_granted_offset !== exp_r.granted) begin
          $error("granted_offset expected %0d actual %0d", exp_r.granted,
                 out_granted_offset);
          fail_count++;
        end
        if (out_used_total !== exp_r.used) begin
          $error("used_total expected %0d actual %0d", exp_r.used, out_used_total);
          fail_count++;
        end
        if (out_blocks_now !== exp_r.blocks) begin
          $error("blocks_now expected %0d actual %0d", exp_r.blocks, out_blocks_now);
          fail_count++;
        end
        if (out_heap_pages_now !== exp_r.pages) begin
          $error("heap_pages_now expected %0d actual %0d", exp_r.pages,
                 out_heap_pages_now);
          fail_count++;
        end
      end
    end
  end

  // Directed corners: zero size, null free, bad offsets, double free, merges.
  task automatic test_directed_cases();
    alloc_word(0);
    free_word(0);
    alloc_word(1);
    alloc_word(100);
    alloc_word(16);
    free_word(7);
    free_word(41);
    free_word(262143);
    free_word(HEAD_BYTES + 16);
    free_word(live_offsets[1]);
    free_word(live_offsets[1]);
    free_word(live_offsets[0]);
    free_word(live_offsets[2]);
    live_offsets.delete();
    alloc_word(5000);
    alloc_word(262144);
    alloc_word(524287);
    alloc_word(4000);
    free_word(live_offsets[0]);
    free_word(live_offsets[1]);
    live_offsets.delete();
  endtask

  // Page limit extremes: growth blocked and limit below current heap.
  task automatic test_page_limits();
    write_page_limit(1);
    alloc_word(4096);
    alloc_word(200);
    write_page_limit(0);
    alloc_word(9000);
    write_page_limit(127);
    alloc_word(200000);
    alloc_word(70000);
    write_page_limit(3);
    alloc_word(8000);
  endtask

  // Mostly allocate and free of live words, with some malformed frees.
  task automatic test_random_traffic(int count, int unsigned lim);
    int unsigned pick;
    int unsigned idx;
    write_page_limit(lim);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 19) == 0) alloc_word($urandom_range(0, 524287));
        else alloc_word($urandom_range(1, 600));
      end else if (pick < 85 && live_offsets.size() != 0) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        free_word(live_offsets[idx]);
        if ($urandom_range(0, 3) != 0) live_offsets.delete(idx);
      end else begin
        free_word($urandom_range(0, 262143));
      end
    end
  endtask

  initial begin
    fail_count = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_ALLOC;
    in_request_bytes = '0;
    in_user_offset = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int g = 0; g < ARENA_GR; g++) begin
      blk_size[g] = 0;
      blk_used[g] = 1'b0;
      blk_prev[g] = 0;
    end
    heap_reset();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_page_limits();
    test_random_traffic(250, 64);
    test_random_traffic(250, 4);
    drain_results();
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("first_fit_heap_allocator test passed");
    else $display("first_fit_heap_allocator test failed");
    $finish;
  end

endmodule
